### rtl/ucrh_pkg.sv
// ---------------------------------------------------------------------------
// ucrh_pkg: shared types, codes and descriptor ROMs
// Common definitions for the control request handler front and back ends.
// ---------------------------------------------------------------------------
package ucrh_pkg;

    localparam int CONTROL_PACKET_BYTES = 64;

    typedef enum logic [1:0] {
        CMD_BUS_RESET = 2'd0,
        CMD_SETUP     = 2'd1,
        CMD_DATA_DONE = 2'd2,
        CMD_OUT_BYTE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_DATA       = 3'd0,
        ACT_ZLP        = 3'd1,
        ACT_STALL      = 3'd2,
        ACT_STATUS     = 3'd3,
        ACT_ARM_OUT    = 3'd4,
        ACT_SET_ADDR   = 3'd5,
        ACT_ENABLE_EPS = 3'd6,
        ACT_CTRL_ONLY  = 3'd7
    } t_action;

    // Source of a streamed block.
    typedef enum logic [2:0] {
        SRC_DEVICE = 3'd0,
        SRC_CONFIG = 3'd1,
        SRC_STR0   = 3'd2,
        SRC_STR1   = 3'd3,
        SRC_STR2   = 3'd4,
        SRC_STR3   = 3'd5,
        SRC_LINE   = 3'd6,
        SRC_ZERO   = 3'd7
    } t_src;

    // Classified job passed from the front end to the back end.
    // A job emits up to two single actions (first, second), or a stream.
    typedef struct packed {
        logic       is_stream;
        t_src       src;
        logic [6:0] len;        // stream length, 0 means one zero-length send
        logic       has_first;
        t_action    first;
        logic [6:0] first_addr;
        logic       has_second;
        t_action    second;
        logic       cfg;        // configured flag after this request
    } t_job;

    localparam int JOB_W = $bits(t_job);

    function automatic logic [7:0] rom_byte(input t_src src, input logic [6:0] i);
        logic [7:0] b;
        b = 8'h00;
        case (src)
            SRC_DEVICE: begin
                case (i)
                    7'd0: b = 8'd18;  7'd1: b = 8'd1;   7'd2: b = 8'h00; 7'd3: b = 8'h02;
                    7'd4: b = 8'h02;  7'd5: b = 8'h00;  7'd6: b = 8'h00;
                    7'd7: b = 8'(CONTROL_PACKET_BYTES);
                    7'd8: b = 8'h15;  7'd9: b = 8'h19;  7'd10: b = 8'h20; 7'd11: b = 8'h52;
                    7'd12: b = 8'h00; 7'd13: b = 8'h01; 7'd14: b = 8'd1;  7'd15: b = 8'd2;
                    7'd16: b = 8'd3;  7'd17: b = 8'd1;
                    default: b = 8'h00;
                endcase
            end
            SRC_CONFIG: begin
                case (i)
                    7'd0: b = 8'd9;    7'd1: b = 8'd2;    7'd2: b = 8'd67;  7'd3: b = 8'd0;
                    7'd4: b = 8'd2;    7'd5: b = 8'd1;    7'd6: b = 8'd0;   7'd7: b = 8'hC0;
                    7'd8: b = 8'd50;
                    7'd9: b = 8'd9;    7'd10: b = 8'd4;   7'd11: b = 8'd0;  7'd12: b = 8'd0;
                    7'd13: b = 8'd1;   7'd14: b = 8'h02;  7'd15: b = 8'h02; 7'd16: b = 8'h01;
                    7'd17: b = 8'd0;
                    7'd18: b = 8'd5;   7'd19: b = 8'h24;  7'd20: b = 8'h00; 7'd21: b = 8'h10;
                    7'd22: b = 8'h01;
                    7'd23: b = 8'd5;   7'd24: b = 8'h24;  7'd25: b = 8'h01; 7'd26: b = 8'h00;
                    7'd27: b = 8'd1;
                    7'd28: b = 8'd4;   7'd29: b = 8'h24;  7'd30: b = 8'h02; 7'd31: b = 8'h02;
                    7'd32: b = 8'd5;   7'd33: b = 8'h24;  7'd34: b = 8'h06; 7'd35: b = 8'd0;
                    7'd36: b = 8'd1;
                    7'd37: b = 8'd7;   7'd38: b = 8'd5;   7'd39: b = 8'h81; 7'd40: b = 8'h03;
                    7'd41: b = 8'd8;   7'd42: b = 8'd0;   7'd43: b = 8'd255;
                    7'd44: b = 8'd9;   7'd45: b = 8'd4;   7'd46: b = 8'd1;  7'd47: b = 8'd0;
                    7'd48: b = 8'd2;   7'd49: b = 8'h0A;  7'd50: b = 8'h00; 7'd51: b = 8'h00;
                    7'd52: b = 8'd0;
                    7'd53: b = 8'd7;   7'd54: b = 8'd5;   7'd55: b = 8'h02; 7'd56: b = 8'h02;
                    7'd57: b = 8'd64;  7'd58: b = 8'd0;   7'd59: b = 8'd0;
                    7'd60: b = 8'd7;   7'd61: b = 8'd5;   7'd62: b = 8'h82; 7'd63: b = 8'h02;
                    7'd64: b = 8'd64;  7'd65: b = 8'd0;   7'd66: b = 8'd0;
                    default: b = 8'h00;
                endcase
            end
            SRC_STR0: begin
                case (i)
                    7'd0: b = 8'd4; 7'd1: b = 8'd3; 7'd2: b = 8'h09; 7'd3: b = 8'h04;
                    default: b = 8'h00;
                endcase
            end
            SRC_STR1: begin
                case (i)
                    7'd0: b = 8'd14; 7'd1: b = 8'd3; 7'd2: b = 8'h4E; 7'd4: b = 8'h6F;
                    7'd6: b = 8'h72; 7'd8: b = 8'h64; 7'd10: b = 8'h69; 7'd12: b = 8'h63;
                    default: b = 8'h00;
                endcase
            end
            SRC_STR2: begin
                case (i)
                    7'd0: b = 8'd20; 7'd1: b = 8'd3; 7'd2: b = 8'h75; 7'd4: b = 8'h4D;
                    7'd6: b = 8'h79; 7'd8: b = 8'h6F; 7'd10: b = 8'h20; 7'd12: b = 8'h52;
                    7'd14: b = 8'h78; 7'd16: b = 8'h20; 7'd18: b = 8'h20;
                    default: b = 8'h00;
                endcase
            end
            SRC_STR3: begin
                case (i)
                    7'd0: b = 8'd10; 7'd1: b = 8'd3; 7'd2: b = 8'h31; 7'd4: b = 8'h32;
                    7'd6: b = 8'h33; 7'd8: b = 8'h34;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### rtl/usb_control_request_handler.sv
// ---------------------------------------------------------------------------
// usb_control_request_handler: CDC ACM control endpoint handler
// Decodes control endpoint events and streams the endpoint actions.
// ---------------------------------------------------------------------------
// Usage: each input request (valid/ready) carries one event: bus reset,
// setup packet, data done or one OUT byte. Results leave on the output
// channel (valid/ready), one action per cycle while the receiver is ready,
// with last_of_run marking the final result of a request. A data-done
// with nothing pending and every OUT byte produce no result.
// The decoder takes a request and pushes a job into a two-entry queue;
// the sequencer then emits one result per cycle unless the receiver
// stalls, up to 64 results for a descriptor. The job is registered in the
// queue and each result in the output register.
// An OUT byte is held off while the queue holds a job, so a queued line
// coding read always streams the bytes stored when it was requested.
// Reset clears the flags, the address and the queue and restores the
// default line coding (115200 baud, 8 data bits). When the receiver stalls
// the output register holds; the queue fills and then input ready drops.
// ---------------------------------------------------------------------------
module usb_control_request_handler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_request_type,
    input  logic [7:0]  i_request_code,
    input  logic [15:0] i_request_value,
    input  logic [15:0] i_request_length,
    input  logic [7:0]  i_out_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [7:0]  o_data_byte,
    output logic        o_last_of_run,
    output logic [6:0]  o_new_address,
    output logic        o_is_configured
);
    import ucrh_pkg::*;

    t_job       f_job, q_job;
    logic       f_valid, f_ready, q_valid, q_ready;
    logic [2:0] lc_idx;
    logic       lc_we;
    logic [7:0] lc_data;
    logic [7:0] r_lc [7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc[0] <= 8'h00; r_lc[1] <= 8'hC2; r_lc[2] <= 8'h01; r_lc[3] <= 8'h00;
            r_lc[4] <= 8'h00; r_lc[5] <= 8'h00; r_lc[6] <= 8'h08;
        end else if (lc_we && lc_idx != 3'd7) begin
            r_lc[lc_idx] <= lc_data;
        end
    end

    ucrh_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_cmd, .i_request_type, .i_request_code, .i_request_value,
        .i_request_length, .i_out_data,
        .o_job_valid(f_valid), .i_job_ready(f_ready), .i_lc_busy(q_valid),
        .o_job(f_job),
        .o_lc_index(lc_idx), .o_lc_we(lc_we), .o_lc_data(lc_data)
    );

    ucrh_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    ucrh_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(q_valid), .o_job_ready(q_ready), .i_job(q_job),
        .i_lc_byte0(r_lc[0]), .i_lc_byte1(r_lc[1]), .i_lc_byte2(r_lc[2]),
        .i_lc_byte3(r_lc[3]), .i_lc_byte4(r_lc[4]), .i_lc_byte5(r_lc[5]),
        .i_lc_byte6(r_lc[6]),
        .o_valid, .i_ready, .o_action, .o_data_byte, .o_last_of_run,
        .o_new_address, .o_is_configured
    );
endmodule

### rtl/ucrh_front.sv
// ---------------------------------------------------------------------------
// ucrh_front: request decoder
// Accepts requests, updates the handler state and classifies requests into
// jobs for the back end; OUT bytes and idle data-done events give no job.
// ---------------------------------------------------------------------------
module ucrh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_cmd,
    input  logic [7:0]          i_request_type,
    input  logic [7:0]          i_request_code,
    input  logic [15:0]         i_request_value,
    input  logic [15:0]         i_request_length,
    input  logic [7:0]          i_out_data,
    output logic                o_job_valid,
    input  logic                i_job_ready,
    input  logic                i_lc_busy,
    output ucrh_pkg::t_job      o_job,
    output logic [2:0]          o_lc_index,
    output logic                o_lc_we,
    output logic [7:0]          o_lc_data
);
    import ucrh_pkg::*;

    logic       r_cfg, n_cfg;
    logic [6:0] r_addr, n_addr;
    logic       r_addr_pend, n_addr_pend;
    logic       r_out_pend, n_out_pend;
    logic [2:0] r_idx, n_idx;
    logic       emit;
    logic       acc;
    t_job       job;

    // An OUT byte waits until the queue holds no job, so no queued job can still read the line coding.
    assign o_ready   = i_job_ready & ~(i_lc_busy & (t_cmd'(i_cmd) == CMD_OUT_BYTE));
    assign acc       = i_valid & o_ready;
    assign o_job_valid = acc & emit;
    assign o_job     = job;
    assign o_lc_index = r_idx;
    assign o_lc_data = i_out_data;
    assign o_lc_we   = acc & (t_cmd'(i_cmd) == CMD_OUT_BYTE) & r_out_pend & (r_idx < 3'd7);

    function automatic logic [6:0] clip(input logic [15:0] req, input logic [6:0] size);
        logic [15:0] l;
        l = (req < {9'd0, size}) ? req : {9'd0, size};
        if (l > 16'(CONTROL_PACKET_BYTES)) begin
            l = 16'(CONTROL_PACKET_BYTES);
        end
        return l[6:0];
    endfunction

    always_comb begin
        n_cfg       = r_cfg;
        n_addr      = r_addr;
        n_addr_pend = r_addr_pend;
        n_out_pend  = r_out_pend;
        n_idx       = r_idx;
        emit        = 1'b1;
        job         = '0;
        job.src     = SRC_ZERO;
        job.first   = ACT_STALL;
        job.second  = ACT_STATUS;
        job.has_first = 1'b1;
        case (t_cmd'(i_cmd))
            CMD_BUS_RESET: begin
                n_cfg = 1'b0;
                n_addr = 7'd0;
                job.first = ACT_CTRL_ONLY;
            end
            CMD_SETUP: begin
                if (i_request_type[6:5] == 2'b00) begin
                    case (i_request_code)
                        8'h00: begin
                            job.is_stream = 1'b1;
                            job.src = SRC_ZERO;
                            job.len = 7'd2;
                        end
                        8'h05: begin
                            n_addr = i_request_value[6:0];
                            n_addr_pend = 1'b1;
                            job.first = ACT_STATUS;
                        end
                        8'h06: begin
                            job.is_stream = 1'b1;
                            if (i_request_value[15:8] == 8'd1) begin
                                job.src = SRC_DEVICE;
                                job.len = clip(i_request_length, 7'd18);
                            end else if (i_request_value[15:8] == 8'd2) begin
                                job.src = SRC_CONFIG;
                                job.len = clip(i_request_length, 7'd67);
                            end else if (i_request_value[15:8] == 8'd3
                                         && i_request_value[7:0] == 8'd0) begin
                                job.src = SRC_STR0;
                                job.len = clip(i_request_length, 7'd4);
                            end else if (i_request_value[15:8] == 8'd3
                                         && i_request_value[7:0] == 8'd1) begin
                                job.src = SRC_STR1;
                                job.len = clip(i_request_length, 7'd14);
                            end else if (i_request_value[15:8] == 8'd3
                                         && i_request_value[7:0] == 8'd2) begin
                                job.src = SRC_STR2;
                                job.len = clip(i_request_length, 7'd20);
                            end else if (i_request_value[15:8] == 8'd3
                                         && i_request_value[7:0] == 8'd3) begin
                                job.src = SRC_STR3;
                                job.len = clip(i_request_length, 7'd10);
                            end else begin
                                job.is_stream = 1'b0;
                            end
                        end
                        8'h09: begin
                            n_cfg = (i_request_value != 16'd0);
                            job.first = ACT_ENABLE_EPS;
                            job.has_second = 1'b1;
                        end
                        default: ;
                    endcase
                end else if (i_request_type[6:5] == 2'b01) begin
                    case (i_request_code)
                        8'h20: begin
                            n_out_pend = 1'b1;
                            n_idx = 3'd0;
                            job.first = ACT_ARM_OUT;
                        end
                        8'h21: begin
                            job.is_stream = 1'b1;
                            job.src = SRC_LINE;
                            job.len = 7'd7;
                        end
                        8'h22: job.first = ACT_STATUS;
                        default: ;
                    endcase
                end
            end
            CMD_DATA_DONE: begin
                job.has_first = r_addr_pend;
                job.first = ACT_SET_ADDR;
                job.first_addr = r_addr;
                job.has_second = r_out_pend;
                emit = r_addr_pend | r_out_pend;
                n_addr_pend = 1'b0;
                n_out_pend = 1'b0;
            end
            default: begin
                emit = 1'b0;
                if (r_out_pend && r_idx < 3'd7) begin
                    n_idx = r_idx + 3'd1;
                end
            end
        endcase
        job.cfg = n_cfg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 1'b0;
            r_addr <= 7'd0;
            r_addr_pend <= 1'b0;
            r_out_pend <= 1'b0;
            r_idx <= 3'd0;
        end else if (acc) begin
            r_cfg <= n_cfg;
            r_addr <= n_addr;
            r_addr_pend <= n_addr_pend;
            r_out_pend <= n_out_pend;
            r_idx <= n_idx;
        end
    end
endmodule

### rtl/ucrh_queue.sv
// ---------------------------------------------------------------------------
// ucrh_queue: job queue
// Two-entry queue between the decoder and the response sequencer.
// ---------------------------------------------------------------------------
module ucrh_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ucrh_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output ucrh_pkg::t_job o_job
);
    import ucrh_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid & o_ready;
    assign pop     = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### rtl/ucrh_back.sv
// ---------------------------------------------------------------------------
// ucrh_back: response sequencer
// Expands one job into its result stream through a registered output stage.
// ---------------------------------------------------------------------------
module ucrh_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  ucrh_pkg::t_job i_job,
    input  logic [7:0]     i_lc_byte0,
    input  logic [7:0]     i_lc_byte1,
    input  logic [7:0]     i_lc_byte2,
    input  logic [7:0]     i_lc_byte3,
    input  logic [7:0]     i_lc_byte4,
    input  logic [7:0]     i_lc_byte5,
    input  logic [7:0]     i_lc_byte6,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_action,
    output logic [7:0]     o_data_byte,
    output logic           o_last_of_run,
    output logic [6:0]     o_new_address,
    output logic           o_is_configured
);
    import ucrh_pkg::*;

    // Step within a job: 0..len-1 for streams, 0/1 for single actions.
    logic [6:0] r_step;
    logic       r_ov;
    logic       adv;
    logic       last;
    logic       first_phase;
    t_action    act;
    logic [7:0] dbyte;
    logic [6:0] addr;

    assign adv = i_job_valid & (~r_ov | i_ready);
    assign first_phase = (r_step == 7'd0) & i_job.has_first;

    always_comb begin
        dbyte = 8'h00;
        addr = 7'd0;
        act = ACT_STATUS;
        last = 1'b1;
        if (i_job.is_stream) begin
            if (i_job.len == 7'd0) begin
                act = ACT_ZLP;
            end else begin
                act = ACT_DATA;
                last = (r_step == i_job.len - 7'd1);
                if (i_job.src == SRC_LINE) begin
                    case (r_step[2:0])
                        3'd0: dbyte = i_lc_byte0;
                        3'd1: dbyte = i_lc_byte1;
                        3'd2: dbyte = i_lc_byte2;
                        3'd3: dbyte = i_lc_byte3;
                        3'd4: dbyte = i_lc_byte4;
                        3'd5: dbyte = i_lc_byte5;
                        3'd6: dbyte = i_lc_byte6;
                        default: dbyte = 8'h00;
                    endcase
                end else begin
                    dbyte = rom_byte(i_job.src, r_step);
                end
            end
        end else if (first_phase) begin
            act = i_job.first;
            addr = (i_job.first == ACT_SET_ADDR) ? i_job.first_addr : 7'd0;
            last = ~i_job.has_second;
        end else begin
            act = i_job.second;
        end
    end

    assign o_job_ready = adv & last;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_action <= act;
            o_data_byte <= dbyte;
            o_last_of_run <= last;
            o_new_address <= addr;
            o_is_configured <= i_job.cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_step <= 7'd0;
        end else begin
            if (adv) begin
                r_ov <= 1'b1;
                r_step <= last ? 7'd0 : r_step + 7'd1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule
